### rtl/rap_pkg.sv
// shared types and codes of the rgb alpha channel packer
package rap_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_GREEN_INV     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHA_INV     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHA_STRETCH = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ALPHA_SEL     = 2'd3;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_PACK    = 1'b1;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;
  localparam logic [1:0] CHAN_ALPHA = 2'd3;

  localparam int unsigned USER_BITS = 2;

  typedef struct packed {
    logic load;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic normalize;
  } status_t;

endpackage

### rtl/rap_div.sv
// restoring divider, one quotient bit per cycle, saturates when the quotient would overflow
module rap_div #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] numer,
  input  logic [WIDTH-1:0] denom,
  output logic             done,
  output logic [WIDTH-1:0] quot
);

  localparam int unsigned CNT_BITS = $clog2(WIDTH + 1);
  localparam logic [WIDTH-1:0] FULL = {WIDTH{1'b1}};

  logic [2*WIDTH-1:0] scaled;
  logic [WIDTH-1:0]   rem;
  logic [WIDTH-1:0]   low;
  logic [WIDTH-1:0]   q;
  logic [WIDTH-1:0]   divisor;
  logic               sat;
  logic               busy;
  logic [CNT_BITS-1:0] cnt;
  logic [WIDTH:0]     trial;

  // numer * full scale, top half is below denom unless saturated
  assign scaled = ({{WIDTH{1'b0}}, numer} << WIDTH) - {{WIDTH{1'b0}}, numer};
  assign trial  = {rem, low[WIDTH-1]} - {1'b0, divisor};
  assign quot   = sat ? FULL : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= scaled[2*WIDTH-1:WIDTH];
      low     <= scaled[WIDTH-1:0];
      divisor <= denom;
      sat     <= (numer >= denom);
      q       <= '0;
    end else if (busy) begin
      low <= {low[WIDTH-2:0], 1'b0};
      if (!trial[WIDTH]) begin
        rem <= trial[WIDTH-1:0];
        q   <= {q[WIDTH-2:0], 1'b1};
      end else begin
        rem <= {rem[WIDTH-2:0], low[WIDTH-1]};
        q   <= {q[WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/rap_datapath.sv
// datapath: configuration, running min and max, beat holding, normalizing and output conversion
module rap_datapath #(
  parameter int unsigned CHAN_BITS = 16,
  parameter int unsigned OUT_BITS  = 8,
  parameter int unsigned IN_W      = 112,
  parameter int unsigned OUT_W     = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rap_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rap_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [IN_W-1:0]                    s_tdata,
  input  logic [rap_pkg::USER_BITS-1:0]      s_tuser,
  input  rap_pkg::cmd_t                      cmd,
  output rap_pkg::status_t                   status,
  output logic [OUT_W-1:0]                   m_tdata
);
  import rap_pkg::*;

  localparam int unsigned C = CHAN_BITS;
  localparam int unsigned O = OUT_BITS;
  localparam int unsigned X = C + O + 1;
  localparam logic [C-1:0] FULL = {C{1'b1}};
  localparam logic [X-1:0] M_X    = X'({C{1'b1}});
  localparam logic [X-1:0] M2_X   = X'({C{1'b1}}) << 1;
  localparam logic [X-1:0] HALF_X = X'({C{1'b1}}) >> 1;

  logic       green_inv;
  logic       alpha_inv;
  logic       alpha_stretch;
  logic [1:0] alpha_sel;

  logic [C-1:0] chan_min;
  logic [C-1:0] chan_max;
  logic [C-1:0] red_hold;
  logic [C-1:0] green_hold;
  logic [C-1:0] blue_hold;
  logic [C-1:0] alpha_hold;
  logic [C-1:0] diff_hold;
  logic [C-1:0] range_hold;

  logic [C-1:0] alpha_in;
  logic [C-1:0] base_min;
  logic [C-1:0] base_max;
  logic [C-1:0] diff_in;
  logic [C-1:0] range_in;
  logic [C-1:0] quot;
  logic [C-1:0] alpha_norm;
  logic [C-1:0] alpha_fin;
  logic         div_done;

  // round to nearest: (v * out full + chan full / 2) / chan full
  function automatic logic [O-1:0] to_out(input logic [C-1:0] v);
    logic [X-1:0] x;
    logic [X-1:0] t;
    logic [X-1:0] q1;
    logic [X-1:0] r;
    logic [X-1:0] q;
    x  = (X'(v) << O) - X'(v) + HALF_X;
    t  = x + (x >> C);
    q1 = t >> C;
    r  = x - (q1 << C) + q1;
    if (r >= M2_X) begin
      q = q1 + X'(2);
    end else if (r >= M_X) begin
      q = q1 + X'(1);
    end else begin
      q = q1;
    end
    return q[O-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      green_inv     <= 1'b0;
      alpha_inv     <= 1'b0;
      alpha_stretch <= 1'b0;
      alpha_sel     <= CHAN_RED;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GREEN_INV:     green_inv     <= cfg_data[0];
        CFG_ALPHA_INV:     alpha_inv     <= cfg_data[0];
        CFG_ALPHA_STRETCH: alpha_stretch <= cfg_data[0];
        CFG_ALPHA_SEL:     alpha_sel     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (alpha_sel)
      CHAN_RED:   alpha_in = s_tdata[3*C +: C];
      CHAN_GREEN: alpha_in = s_tdata[4*C +: C];
      CHAN_BLUE:  alpha_in = s_tdata[5*C +: C];
      CHAN_ALPHA: alpha_in = s_tdata[6*C +: C];
      default:    alpha_in = s_tdata[3*C +: C];
    endcase
  end

  // first pixel of a measure pass starts from the empty interval
  assign base_min = s_tuser[1] ? FULL : chan_min;
  assign base_max = s_tuser[1] ? '0 : chan_max;
  assign diff_in  = (alpha_in > chan_min) ? alpha_in - chan_min : '0;
  assign range_in = (chan_max > chan_min) ? chan_max - chan_min : C'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_min <= FULL;
      chan_max <= '0;
    end else if (cmd.load && s_tuser[0] == REQ_MEASURE) begin
      chan_min <= (alpha_in < base_min) ? alpha_in : base_min;
      chan_max <= (alpha_in > base_max) ? alpha_in : base_max;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      red_hold   <= s_tdata[0 +: C];
      green_hold <= green_inv ? FULL - s_tdata[C +: C] : s_tdata[C +: C];
      blue_hold  <= s_tdata[2*C +: C];
      alpha_hold <= alpha_in;
      diff_hold  <= diff_in;
      range_hold <= range_in;
    end
  end

  rap_div #(
    .WIDTH(C)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (diff_hold),
    .denom (range_hold),
    .done  (div_done),
    .quot  (quot)
  );

  assign alpha_norm = alpha_stretch ? quot : alpha_hold;
  assign alpha_fin  = alpha_inv ? FULL - alpha_norm : alpha_norm;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= OUT_W'({to_out(alpha_fin), to_out(blue_hold), to_out(green_hold),
                         to_out(red_hold)});
    end
  end

  assign status.div_done  = div_done;
  assign status.normalize = alpha_stretch;

endmodule

### rtl/rap_ctrl.sv
// controller: beat acceptance, divider sequencing and output register handshake
module rap_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             req_type,
  output logic             s_tready,
  input  logic             m_tready,
  output logic             m_tvalid,
  output rap_pkg::cmd_t    cmd,
  input  rap_pkg::status_t status
);
  import rap_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       m_tvalid_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (req_type == REQ_PACK) begin
            state_next = status.normalize ? S_START : S_OUT;
          end
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while a beat is pending");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");

  a_start_to_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_START) |=> (state == S_DIV))
    else $error("divider start not followed by wait");

  a_valid_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_OUT))
    else $error("output beat raised outside the output state");

endmodule

### rtl/rgb_alpha_channel_packer.sv
// top level of the rgb alpha channel packer
//
// input stream s_*: one beat per pixel. tuser[0] is the kind (0 measure, 1 pack),
// tuser[1] marks the first pixel of a measure pass. a measure beat folds the
// selected channel of the alpha source pixel into a running min and max and
// gives no output beat. a pack beat gives one rgba beat on
// m_* with each channel rounded to OUT_BITS.
// a pack beat without normalizing goes from the idle to the output state; with
// normalizing it first passes the start and divide states, where the
// one-bit-per-cycle divider scales alpha by the measured range. the output
// state loads the output register and raises m_tvalid. one beat is in work at
// a time: measure beats every cycle while idle; a pack beat blocks the input.
// the output register holds a finished beat while the next input beat is taken;
// a stalled receiver holds m_tdata steady and blocks the next pack beat only
// when it reaches the output stage.
// configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; the user must do so only while idle, the block does not enforce it.
// reset (rst, synchronous): min all ones, max zero, configuration registers
// zero, no output beat pending; data holding registers are not reset.
module rgb_alpha_channel_packer #(
  parameter int unsigned CHAN_BITS = 16,
  parameter int unsigned OUT_BITS  = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rap_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rap_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // red_in, green_in, blue_in, src_chan0, src_chan1, src_chan2, src_chan3
  input  logic [((7*CHAN_BITS+7)/8)*8-1:0]    s_tdata,
  // req_type, first_pixel
  input  logic [rap_pkg::USER_BITS-1:0]       s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [((4*OUT_BITS+7)/8)*8-1:0]     m_tdata
);
  import rap_pkg::*;

  localparam int unsigned IN_W  = ((7*CHAN_BITS+7)/8)*8;
  localparam int unsigned OUT_W = ((4*OUT_BITS+7)/8)*8;

  cmd_t    cmd;
  status_t status;

  rap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .req_type (s_tuser[0]),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd),
    .status   (status)
  );

  rap_datapath #(
    .CHAN_BITS (CHAN_BITS),
    .OUT_BITS  (OUT_BITS),
    .IN_W      (IN_W),
    .OUT_W     (OUT_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .status    (status),
    .m_tdata   (m_tdata)
  );

endmodule
